// File: design/assert_macros.svh
// assertion macros used by the solver sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/jls_pkg.sv
// types, constants and helpers shared by the jacobi solver
`default_nettype none
package jls_pkg;
	localparam int MaxOrder = 8;
	localparam int IdxW = $clog2(MaxOrder);
	localparam int MemAw = 2 * IdxW;
	localparam int OrdW = 4;
	localparam int TolW = 41;
	localparam int IterW = 16;
	localparam int ValW = 64;
	localparam int FracW = 40;
	localparam int CntW = 7;
	localparam logic [ValW-1:0] QOne = 64'h0000_0100_0000_0000;
	localparam logic signed [ValW-1:0] SMax = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [ValW-1:0] SMin = 64'sh8000_0000_0000_0000;

	localparam logic [1:0] ReqMatrix = 2'd0;
	localparam logic [1:0] ReqRhs = 2'd1;
	localparam logic [1:0] ReqGuess = 2'd2;
	localparam logic [1:0] ReqSolve = 2'd3;

	localparam logic [1:0] RegOrder = 2'd0;
	localparam logic [1:0] RegTol = 2'd1;
	localparam logic [1:0] RegIter = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] row;
		logic [2:0] col;
		logic signed [63:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0] index;
		logic signed [63:0] solution;
		logic converged;
		logic [15:0] sweeps;
		logic zero_pivot;
		logic last;
	} res_t;

	// commands from controller to datapath
	typedef struct packed {
		logic wr_load;
		logic [1:0] load_kind;
		logic [IdxW-1:0] load_row;
		logic [IdxW-1:0] load_col;
		logic row_init;
		logic [IdxW-1:0] i;
		logic [IdxW-1:0] j;
		logic mem_rd;
		logic mul_start;
		logic mul_step;
		logic mac_sub;
		logic mac_diag;
		logic div_start;
		logic div_step;
		logic row_done;
		logic sweep_init;
		logic sweep_done;
		logic solve_init;
		logic copy_prev;
		logic [IdxW-1:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic conv;
		logic [IterW-1:0] sweeps;
	} sts_t;

	function automatic logic signed [ValW-1:0] sat_sub(input logic signed [ValW-1:0] a,
		input logic signed [ValW-1:0] b);
		logic signed [ValW-1:0] r;
		begin
			r = a - b;
			if ((a[ValW-1] != b[ValW-1]) && (r[ValW-1] != a[ValW-1]))
				return a[ValW-1] ? SMin : SMax;
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// File: design/jacobi_linear_solver.sv
// jacobi solver top level: apb registers, sequencer and datapath
//  channel   | handshake          | payload
//  request   | start / busy       | req (req_t)
//  result    | res_valid strobe   | res (res_t)
//  config    | apb psel/penable   | order, tolerance, max_iterations
// a solve runs one convergence check per sweep plus a final one, and per sweep n rows:
// each element goes through the four-step multiplier and each row through the
// 128-step serial divider; then n results are emitted
// no reset clearing pass: stores are undefined until written
// results are strobed for one cycle and cannot be stalled
`default_nettype none
module jacobi_linear_solver import jls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t req,
	output logic res_valid,
	output res_t res,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	logic [OrdW-1:0] order_q;
	logic [TolW-1:0] tol_q;
	logic [IterW-1:0] iter_q;
	cmd_t cmd;
	logic conv, mul_busy, div_busy, zp, emit, emit_last;
	logic [IterW-1:0] sweeps;
	logic signed [ValW-1:0] out_value;
	logic [1:0] reg_sel;

	assign pready = 1'b1;
	assign reg_sel = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= OrdW'(MaxOrder);
			tol_q <= TolW'(1);
			iter_q <= IterW'(1000);
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			case (reg_sel)
				RegOrder: order_q <= pwdata[OrdW-1:0];
				RegTol: tol_q <= pwdata[TolW-1:0];
				RegIter: iter_q <= pwdata[IterW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			RegOrder: prdata = 64'(order_q);
			RegTol: prdata = 64'(tol_q);
			RegIter: prdata = 64'(iter_q);
			default: prdata = '0;
		endcase
	end

	jls_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.order(order_q), .max_iterations(iter_q), .conv(conv),
		.mul_busy(mul_busy), .div_busy(div_busy), .cmd(cmd), .busy(busy), .emit(emit),
		.emit_last(emit_last), .sweeps(sweeps)
	);

	jls_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .load_value(req.value),
		.tolerance(tol_q), .conv(conv), .mul_busy(mul_busy), .div_busy(div_busy),
		.out_value(out_value), .zp(zp)
	);

	assign res_valid = emit;
	always_comb begin
		res.index = cmd.out_idx;
		res.solution = out_value;
		res.converged = conv;
		res.sweeps = sweeps;
		res.zero_pivot = zp;
		res.last = emit_last;
	end
endmodule
`default_nettype wire

// File: design/jls_datapath.sv
// jacobi datapath: stores, serial multiplier, serial divider
`default_nettype none
module jls_datapath import jls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	input wire logic signed [ValW-1:0] load_value,
	input wire logic [TolW-1:0] tolerance,
	output logic conv,
	output logic mul_busy,
	output logic div_busy,
	output logic signed [ValW-1:0] out_value,
	output logic zp
);
	logic signed [ValW-1:0] mat_mem [MaxOrder*MaxOrder];
	logic signed [ValW-1:0] rhs_q [MaxOrder];
	logic signed [ValW-1:0] sol_q [MaxOrder];
	logic signed [ValW-1:0] prev_q [MaxOrder];
	logic signed [ValW-1:0] a_s1, p_s1;
	logic signed [ValW-1:0] diag_q, dprod_q, acc_q, worst_q, disc_q;
	logic signed [ValW-1:0] qprod;
	logic [ValW:0] disc_cmp;
	// multiplier state
	logic [ValW-1:0] ma_q, mb_q;
	logic mneg_q;
	logic [2:0] mcnt_q;
	logic [2*ValW-1:0] pm_q, maddend;
	logic [31:0] mx, my;
	logic [ValW-1:0] mpart;
	// divider state
	logic [2*ValW-1:0] dvd_q, quo_q;
	logic [ValW-1:0] rem_q, den_q;
	logic neg_q;
	logic [CntW:0] dcnt_q;
	logic [ValW:0] rshift;
	logic [ValW-1:0] rnext;
	logic take;
	logic signed [ValW-1:0] dev, dev_abs, qsat, zq;

	// matrix memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_load && cmd.load_kind == ReqMatrix)
			mat_mem[{cmd.load_row, cmd.load_col}] <= load_value;
		if (cmd.mem_rd)
			a_s1 <= mat_mem[{cmd.i, cmd.j}];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_load && cmd.load_kind == ReqRhs)
			rhs_q[cmd.load_row] <= load_value;
		if (cmd.copy_prev)
			prev_q <= sol_q;
		if (cmd.mem_rd)
			p_s1 <= prev_q[cmd.j];
		if (cmd.wr_load && cmd.load_kind == ReqGuess)
			sol_q[cmd.load_row] <= load_value;
		else if (cmd.row_done)
			sol_q[cmd.i] <= (diag_q == '0) ? zq : qsat;
	end

	// magnitude multiplier, one 32x32 partial product per cycle
	assign mul_busy = mcnt_q != '0;

	always_comb begin
		case (mcnt_q)
			3'd4: begin
				mx = ma_q[31:0];
				my = mb_q[31:0];
			end
			3'd3: begin
				mx = ma_q[31:0];
				my = mb_q[63:32];
			end
			3'd2: begin
				mx = ma_q[63:32];
				my = mb_q[31:0];
			end
			default: begin
				mx = ma_q[63:32];
				my = mb_q[63:32];
			end
		endcase
		mpart = 64'(mx) * 64'(my);
		case (mcnt_q)
			3'd4: maddend = {64'd0, mpart};
			3'd1: maddend = {mpart, 64'd0};
			default: maddend = {32'd0, mpart, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mcnt_q <= '0;
		else if (cmd.mul_start)
			mcnt_q <= 3'd4;
		else if (cmd.mul_step && mul_busy)
			mcnt_q <= mcnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q <= a_s1[ValW-1] ? 64'(-a_s1) : a_s1;
			mb_q <= p_s1[ValW-1] ? 64'(-p_s1) : p_s1;
			mneg_q <= a_s1[ValW-1] ^ p_s1[ValW-1];
			pm_q <= '0;
		end else if (cmd.mul_step && mul_busy) begin
			pm_q <= pm_q + maddend;
		end
	end

	// floor shift by the fraction width, then saturate
	always_comb begin
		logic [2*ValW-FracW-1:0] qm;
		qm = pm_q[2*ValW-1:FracW];
		if (mneg_q && pm_q[FracW-1:0] != '0)
			qm = qm + (2*ValW-FracW)'(1);
		if (qm[2*ValW-FracW-1:ValW-1] != '0)
			qprod = mneg_q ? SMin : SMax;
		else
			qprod = mneg_q ? -$signed(qm[ValW-1:0]) : $signed(qm[ValW-1:0]);
	end

	assign dev = sat_sub(dprod_q, acc_q);
	assign dev_abs = (dev == SMin) ? SMax : (dev[ValW-1] ? -dev : dev);
	assign zq = acc_q[ValW-1] ? SMin : ((acc_q == '0) ? '0 : SMax);

	// restoring divider, one quotient bit per cycle
	assign rshift = {rem_q, dvd_q[2*ValW-1]};
	assign take = rshift >= {1'b0, den_q};
	assign rnext = take ? 64'(rshift - {1'b0, den_q}) : rshift[ValW-1:0];
	always_comb begin
		if (quo_q[2*ValW-1:ValW-1] != '0)
			qsat = neg_q ? SMin : SMax;
		else
			qsat = neg_q ? -$signed(quo_q[ValW-1:0]) : $signed(quo_q[ValW-1:0]);
	end
	assign div_busy = dcnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dcnt_q <= '0;
		else if (cmd.div_start)
			dcnt_q <= (CntW+1)'(2*ValW);
		else if (cmd.div_step && div_busy)
			dcnt_q <= dcnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			logic [ValW-1:0] n, d;
			n = acc_q[ValW-1] ? 64'(-acc_q) : acc_q;
			d = diag_q[ValW-1] ? 64'(-diag_q) : diag_q;
			dvd_q <= {24'd0, n, 40'd0};
			den_q <= d;
			neg_q <= acc_q[ValW-1] ^ diag_q[ValW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && div_busy) begin
			dvd_q <= {dvd_q[2*ValW-2:0], 1'b0};
			rem_q <= rnext;
			quo_q <= {quo_q[2*ValW-2:0], take};
		end
	end

	// diagonal product kept until the off-diagonal sum is complete
	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			acc_q <= rhs_q[cmd.i];
		end else if (cmd.mac_sub) begin
			acc_q <= sat_sub(acc_q, qprod);
		end
		if (cmd.mac_diag) begin
			diag_q <= a_s1;
			dprod_q <= qprod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			worst_q <= '0;
			disc_q <= $signed(QOne);
			zp <= 1'b0;
		end else begin
			if (cmd.solve_init) begin
				disc_q <= $signed(QOne);
				zp <= 1'b0;
			end
			if (cmd.sweep_init)
				worst_q <= '0;
			else if (cmd.div_start && dev_abs > worst_q)
				worst_q <= dev_abs;
			if (cmd.row_done && diag_q == '0)
				zp <= 1'b1;
			if (cmd.sweep_done)
				disc_q <= worst_q;
		end
	end

	assign disc_cmp = {1'b0, disc_q};
	assign conv = disc_cmp <= {24'd0, tolerance};
	assign out_value = sol_q[cmd.out_idx];
endmodule
`default_nettype wire

// File: design/jls_ctrl.sv
// jacobi sequencer: loads, sweep loop, result emission
`default_nettype none
module jls_ctrl import jls_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire req_t req,
	input wire logic [OrdW-1:0] order,
	input wire logic [IterW-1:0] max_iterations,
	input wire logic conv,
	input wire logic mul_busy,
	input wire logic div_busy,
	output cmd_t cmd,
	output logic busy,
	output logic emit,
	output logic emit_last,
	output logic [IterW-1:0] sweeps
);
`include "assert_macros.svh"
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCheck = 3'd1;
	localparam logic [2:0] StMac = 3'd2;
	localparam logic [2:0] StMulGo = 3'd3;
	localparam logic [2:0] StDiv = 3'd4;
	localparam logic [2:0] StEmit = 3'd5;
	localparam logic [2:0] StDivGo = 3'd6;
	localparam logic [2:0] StMul = 3'd7;

	logic [2:0] state_q;
	logic [IdxW-1:0] i_q, j_q, n_last_q;
	logic [IterW-1:0] sw_q;
	logic fire;

	assign fire = start && !busy;
	assign busy = state_q != StIdle;
	assign sweeps = sw_q;

	always_comb begin
		cmd = '0;
		cmd.wr_load = fire && req.req_type != ReqSolve;
		cmd.load_kind = req.req_type;
		cmd.load_row = req.row;
		cmd.load_col = req.col;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.out_idx = i_q;
		cmd.solve_init = fire && req.req_type == ReqSolve;
		case (state_q)
			StCheck: begin
				if (!conv && sw_q < max_iterations) begin
					cmd.copy_prev = 1'b1;
					cmd.sweep_init = 1'b1;
				end
			end
			StMac: begin
				if (j_q == '0)
					cmd.row_init = 1'b1;
				cmd.mem_rd = 1'b1;
			end
			StMulGo: cmd.mul_start = 1'b1;
			StMul: begin
				cmd.mul_step = 1'b1;
				if (!mul_busy) begin
					cmd.mac_sub = j_q != i_q;
					cmd.mac_diag = j_q == i_q;
				end
			end
			StDivGo: cmd.div_start = 1'b1;
			StDiv: begin
				cmd.div_step = 1'b1;
				cmd.row_done = !div_busy;
				if (!div_busy && i_q == n_last_q)
					cmd.sweep_done = 1'b1;
			end
			default: ;
		endcase
	end

	assign emit = state_q == StEmit;
	assign emit_last = i_q == n_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			i_q <= '0;
			j_q <= '0;
			n_last_q <= '0;
			sw_q <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (cmd.solve_init) begin
						if (order == '0)
							n_last_q <= '0;
						else if (order > OrdW'(MaxOrder))
							n_last_q <= IdxW'(MaxOrder - 1);
						else
							n_last_q <= IdxW'(order - 1'b1);
						sw_q <= '0;
						state_q <= StCheck;
					end
				end
				StCheck: begin
					i_q <= '0;
					j_q <= '0;
					if (cmd.copy_prev)
						state_q <= StMac;
					else
						state_q <= StEmit;
				end
				StMac: state_q <= StMulGo;
				StMulGo: state_q <= StMul;
				StMul: begin
					if (!mul_busy) begin
						if (j_q == n_last_q) begin
							j_q <= '0;
							state_q <= StDivGo;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= StMac;
						end
					end
				end
				StDivGo: state_q <= StDiv;
				StDiv: begin
					if (!div_busy) begin
						if (i_q == n_last_q) begin
							sw_q <= sw_q + 1'b1;
							state_q <= StCheck;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= StMac;
						end
					end
				end
				StEmit: begin
					if (i_q == n_last_q)
						state_q <= StIdle;
					else
						i_q <= i_q + 1'b1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_emit_idle, clk, arst_n, emit, busy, "result while idle")
	`ASSERT_NEXT(a_div_after_go, clk, arst_n, cmd.div_start, div_busy, "divider not started")
	`ASSERT_NEXT(a_mul_after_go, clk, arst_n, cmd.mul_start, mul_busy, "multiplier not started")
	`ASSERT_IMPL(a_mac_bounded, clk, arst_n, cmd.mem_rd, j_q <= n_last_q,
		"mac index out of range")
endmodule
`default_nettype wire
